### sv/vbst_pkg.sv
// shared constants and types for the valid bitmap slot table
package vbst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = SLOT_W + 1;
  localparam int HANDLE_W    = 32;
  localparam int OPCODE_W    = 2;

  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam opcode_t OP_ADD    = 2'd0;
  localparam opcode_t OP_DELETE = 2'd1;
  localparam opcode_t OP_GET    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

endpackage

### sv/valid_bitmap_slot_table.sv
// valid bitmap slot table: handle slots with add, delete and get-n-th requests
//
// requests come in on in_valid/in_stall with opcode, handle and position;
// results leave on out_valid/out_stall with status, slot, found_handle and
// live_count. each request gives exactly one result.
// a request is taken only while the block is idle (in_stall low), then one
// shared slot walker steps through the table one slot per cycle, reading the
// handle memory through its registered read port and testing one slot at a
// time. add walks up to capacity_in_use slots, delete and get walk up to the
// high-water mark. a walk ends at the first hit or once every slot in range
// has been tested; null handles, unused opcodes, out-of-range gets and walks
// of no slots finish without testing any slot. the result becomes valid in
// the same cycle as the block is idle again.
// the result sits in an output register, so a new request is taken while the
// previous result still waits; if the receiver stalls when the next result is
// ready, the walker holds until the output register frees up.
// cfg_we/cfg_data write capacity_in_use (0 or above 64 means 64).
// rst clears all valid bits, the live count, the high-water mark and sets the
// capacity to 64; stored handles are not cleared.
module valid_bitmap_slot_table import vbst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [SLOT_W-1:0]   position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   slot,
  output logic [HANDLE_W-1:0] found_handle,
  output logic [COUNT_W-1:0]  live_count,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [COUNT_W-1:0]     capacity_in_use;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [COUNT_W-1:0]     valid_total, valid_total_next;
  logic [COUNT_W-1:0]     high_water;
  logic [HANDLE_W-1:0]    handle_store [TABLE_DEPTH];

  opcode_t             op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SLOT_W-1:0]   pos_q;
  logic                early;
  status_t             early_status;

  logic [COUNT_W-1:0]  idx;
  logic                p_valid;
  logic [SLOT_W-1:0]   p_idx;
  logic [COUNT_W-1:0]  seen;
  logic [HANDLE_W-1:0] rd_data;

  logic [COUNT_W-1:0] cap_eff, lim_cur;
  logic               accept, issue, hit, done_ready, out_free, advance, finish;
  status_t            res_status, in_early_status;
  logic               in_early;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign cap_eff = (capacity_in_use == '0 || capacity_in_use > DEPTH_COUNT) ?
                   DEPTH_COUNT : capacity_in_use;

  // decisions that need no walk
  always_comb begin
    in_early        = 1'b0;
    in_early_status = ST_MISSING;
    case (opcode)
      OP_ADD, OP_DELETE: begin
        if (handle == '0) begin
          in_early        = 1'b1;
          in_early_status = ST_NULL;
        end
      end
      OP_GET: begin
        if ({1'b0, position} >= valid_total) begin
          in_early = 1'b1;
        end
      end
      default: begin
        in_early = 1'b1;
      end
    endcase
  end

  always_comb begin
    lim_cur = (op_q == OP_ADD) ? cap_eff : high_water;
    issue   = (idx < lim_cur);
    hit     = 1'b0;
    if (p_valid) begin
      case (op_q)
        OP_ADD:    hit = !slot_valid[p_idx];
        OP_DELETE: hit = slot_valid[p_idx] && (rd_data == handle_q);
        OP_GET:    hit = slot_valid[p_idx] && (seen == {1'b0, pos_q});
        default:   hit = 1'b0;
      endcase
    end
    done_ready = early || hit || (!p_valid && !issue);

    if (early) begin
      res_status = early_status;
    end else if (hit) begin
      res_status = ST_OK;
    end else if (op_q == OP_ADD) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_MISSING;
    end

    valid_total_next = valid_total;
    if (!early && hit) begin
      if (op_q == OP_ADD) begin
        valid_total_next = valid_total + 1'b1;
      end else if (op_q == OP_DELETE) begin
        valid_total_next = valid_total - 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    advance    = 1'b0;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (done_ready) begin
          if (out_free) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= DEPTH_COUNT;
    end else if (cfg_we) begin
      capacity_in_use <= cfg_data;
    end
  end

  // request capture and slot walker
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      idx     <= '0;
      seen    <= '0;
      early   <= 1'b0;
    end else if (accept) begin
      op_q         <= opcode;
      handle_q     <= handle;
      pos_q        <= position;
      early        <= in_early;
      early_status <= in_early_status;
      idx          <= '0;
      p_valid      <= 1'b0;
      seen         <= '0;
    end else if (advance) begin
      p_valid <= issue;
      p_idx   <= idx[SLOT_W-1:0];
      if (issue) begin
        idx <= idx + 1'b1;
      end
      if (p_valid && slot_valid[p_idx] && op_q == OP_GET) begin
        seen <= seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && issue) begin
      rd_data <= handle_store[idx[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (finish && !early && hit && op_q == OP_ADD) begin
      handle_store[p_idx] <= handle_q;
    end
  end

  // table state update
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      valid_total <= '0;
      high_water  <= '0;
    end else if (finish && !early && hit) begin
      valid_total <= valid_total_next;
      if (op_q == OP_ADD) begin
        slot_valid[p_idx] <= 1'b1;
        if ({1'b0, p_idx} >= high_water) begin
          high_water <= {1'b0, p_idx} + 1'b1;
        end
      end else if (op_q == OP_DELETE) begin
        slot_valid[p_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status       <= res_status;
      slot         <= (res_status == ST_OK) ? p_idx : '0;
      found_handle <= (res_status == ST_OK && op_q == OP_GET) ? rd_data : '0;
      live_count   <= valid_total_next;
    end
  end

endmodule

### sim/valid_bitmap_slot_table_tb.sv
// testbench for the valid bitmap slot table: directed and random requests
module valid_bitmap_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vbst_pkg::*;

  localparam opcode_t OP_UNUSED = 2'd3;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [HANDLE_W-1:0]   found_handle;
    logic [COUNT_W-1:0]    live_count;
  } slot_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          opcode;
  logic [HANDLE_W-1:0] handle;
  logic [SLOT_W-1:0]   position;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          status;
  logic [SLOT_W-1:0]   slot;
  logic [HANDLE_W-1:0] found_handle;
  logic [COUNT_W-1:0]  live_count;
  logic                cfg_we;
  logic [COUNT_W-1:0]  cfg_data;

  // table model
  logic [HANDLE_W-1:0] stored_handle [TABLE_DEPTH];
  logic                slot_used [TABLE_DEPTH];
  int                  live_total;
  int                  high_mark;
  logic [COUNT_W-1:0]  capacity_reg;

  slot_result_t pending_results[$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  valid_bitmap_slot_table u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .handle       (handle),
    .position     (position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot         (slot),
    .found_handle (found_handle),
    .live_count   (live_count),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int nth_live_slot(input int n);
    int seen;
    seen = 0;
    for (int i = 0; i < high_mark; i++) begin
      if (slot_used[i]) begin
        if (seen == n) return i;
        seen++;
      end
    end
    return -1;
  endfunction

  function automatic slot_result_t apply_request(input opcode_t op,
                                                 input logic [HANDLE_W-1:0] h,
                                                 input logic [SLOT_W-1:0] pos);
    slot_result_t r;
    int cap;
    int hit;
    r.status = ST_MISSING;
    r.slot = '0;
    r.found_handle = '0;
    hit = -1;
    cap = (capacity_reg == '0 || capacity_reg > DEPTH_COUNT) ? TABLE_DEPTH : int'(capacity_reg);
    case (op)
      OP_ADD: begin
        if (h == '0) begin
          r.status = ST_NULL;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < cap && hit < 0; i++)
            if (!slot_used[i]) hit = i;
          if (hit >= 0) begin
            stored_handle[hit] = h;
            slot_used[hit] = 1'b1;
            live_total++;
            if (hit >= high_mark) high_mark = hit + 1;
            r.status = ST_OK;
            r.slot = SLOT_W'(hit);
          end
        end
      end
      OP_DELETE: begin
        if (h == '0) begin
          r.status = ST_NULL;
        end else begin
          for (int i = 0; i < high_mark && hit < 0; i++)
            if (slot_used[i] && stored_handle[i] == h) hit = i;
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            stored_handle[hit] = '0;
            if (live_total > 0) live_total--;
            r.status = ST_OK;
            r.slot = SLOT_W'(hit);
          end
        end
      end
      OP_GET: begin
        if (int'(pos) < live_total) begin
          hit = nth_live_slot(int'(pos));
          if (hit >= 0) begin
            r.status = ST_OK;
            r.slot = SLOT_W'(hit);
            r.found_handle = stored_handle[hit];
          end
        end
      end
      default: ;
    endcase
    r.live_count = COUNT_W'(live_total);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // send one request, with random idle cycles ahead of it
  task automatic send_req(input opcode_t op, input logic [HANDLE_W-1:0] h,
                          input logic [SLOT_W-1:0] pos);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    handle   <= h;
    position <= pos;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(op, h, pos));
  endtask

  task automatic settle_table();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] value);
    settle_table();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity_reg = value;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (slot !== want.slot)
          report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
        if (found_handle !== want.found_handle)
          report_mismatch($sformatf("found_handle %h, want %h", found_handle,
                                    want.found_handle));
        if (live_count !== want.live_count)
          report_mismatch($sformatf("live_count %0d, want %0d", live_count,
                                    want.live_count));
      end
    end
  end

  task automatic test_empty_table();
    send_req(OP_GET, '0, '0);
    send_req(OP_DELETE, 32'h0000_1234, '0);
  endtask

  task automatic test_null_and_unused();
    send_req(OP_ADD, '0, '0);
    send_req(OP_DELETE, '0, 6'd63);
    send_req(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
  endtask

  task automatic test_capacity_and_full();
    write_capacity(COUNT_W'(3));
    send_req(OP_ADD, 32'hFFFF_FFFF, '0);
    send_req(OP_ADD, 32'h0000_0001, '0);
    send_req(OP_ADD, 32'h8000_0000, '0);
    send_req(OP_ADD, 32'h0000_0005, '0);
    send_req(OP_GET, '0, 6'd2);
    send_req(OP_GET, 32'hFFFF_FFFF, 6'd63);
    write_capacity('0);
    send_req(OP_ADD, 32'h0000_0005, '0);
    write_capacity(COUNT_W'(127));
    write_capacity(DEPTH_COUNT);
  endtask

  task automatic test_duplicate_handles();
    send_req(OP_ADD, 32'h0000_0001, '0);
    send_req(OP_DELETE, 32'h0000_0001, '0);
    send_req(OP_GET, '0, 6'd1);
    send_req(OP_ADD, 32'h0000_0007, '0);
    send_req(OP_DELETE, 32'h0000_0001, '0);
    send_req(OP_DELETE, 32'h0000_0001, '0);
  endtask

  // filled slots above a lowered capacity stay visible to delete and get
  task automatic test_lowered_capacity();
    write_capacity(COUNT_W'(1));
    send_req(OP_ADD, 32'h0000_0009, '0);
    send_req(OP_GET, '0, 6'd3);
    send_req(OP_DELETE, 32'h0000_0005, '0);
    send_req(OP_DELETE, 32'hFFFF_FFFF, '0);
    send_req(OP_ADD, 32'h0000_0009, '0);
  endtask

  task automatic test_random_traffic(input int n_requests);
    int seg;
    int k;
    int roll;
    int add_w;
    int pick;
    opcode_t op;
    logic [HANDLE_W-1:0] h;
    logic [SLOT_W-1:0] pos;
    logic [COUNT_W-1:0] cap;
    for (seg = 0; seg < 4; seg++) begin
      case ($urandom_range(4))
        0: cap = '0;
        1: cap = COUNT_W'(1);
        2: cap = DEPTH_COUNT;
        3: cap = COUNT_W'($urandom_range(2, TABLE_DEPTH - 1));
        default: cap = COUNT_W'($urandom_range(TABLE_DEPTH + 1, 127));
      endcase
      write_capacity(cap);
      add_w = $urandom_range(35, 75);
      for (k = 0; k < n_requests / 4; k++) begin
        roll = $urandom_range(99);
        h = $urandom_range(1) ? HANDLE_W'($urandom_range(1, 24)) : HANDLE_W'($urandom);
        pos = SLOT_W'($urandom);
        if (roll < add_w) begin
          op = OP_ADD;
        end else if (roll < add_w + (100 - add_w) * 6 / 10) begin
          op = OP_DELETE;
          pick = (live_total > 0 && $urandom_range(3) != 0) ?
                 nth_live_slot($urandom_range(0, live_total - 1)) : -1;
          if (pick >= 0) h = stored_handle[pick];
        end else if (roll < 94) begin
          op = OP_GET;
          if ($urandom_range(3) != 0)
            pos = SLOT_W'($urandom_range(0, (live_total > 63) ? 63 : live_total));
        end else begin
          op = opcode_t'($urandom_range(3));
          if ($urandom_range(1)) h = '0;
        end
        send_req(op, h, pos);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_ADD;
    handle = '0;
    position = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    send_idle_pct = 19;
    recv_stall_pct = 72;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      stored_handle[i] = '0;
    end
    live_total = 0;
    high_mark = 0;
    capacity_reg = DEPTH_COUNT;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_null_and_unused();
    test_capacity_and_full();
    test_duplicate_handles();
    test_lowered_capacity();
    test_random_traffic(332);
    send_idle_pct = 72;
    recv_stall_pct = 19;
    test_random_traffic(332);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(332);

    settle_table();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
